// ===== hw/rtl/stnsu_pkg.sv =====
// Package with the constants, tables and types of the sound unit.
`default_nettype none
package stnsu_pkg;
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] PREG_CTRL  = 2'd0;
  localparam logic [1:0] PREG_SWEEP = 2'd1;
  localparam logic [1:0] PREG_LO    = 2'd2;
  localparam logic [1:0] PREG_HI    = 2'd3;

  localparam logic [4:0] OFF_STATUS = 5'h15;
  localparam logic [4:0] OFF_FRAME  = 5'h17;
  localparam logic [4:0] OFF_TRI_LIN = 5'h08;
  localparam logic [4:0] OFF_TRI_LO  = 5'h0A;
  localparam logic [4:0] OFF_TRI_HI  = 5'h0B;
  localparam logic [4:0] OFF_NOI_ENV = 5'h0C;
  localparam logic [4:0] OFF_NOI_PER = 5'h0E;
  localparam logic [4:0] OFF_NOI_LEN = 5'h0F;

  localparam logic [14:0] SEQ_Q1 = 15'd3729;
  localparam logic [14:0] SEQ_Q2 = 15'd7457;
  localparam logic [14:0] SEQ_Q3 = 15'd11186;
  localparam logic [14:0] SEQ_Q4 = 15'd14915;
  localparam logic [14:0] SEQ_Q5 = 15'd18641;
  localparam logic [10:0] PERIOD_MAX = 11'h7FF;

  typedef struct packed {
    logic [3:0] vol;
    logic [3:0] decay;
    logic [3:0] divider;
    logic       start;
    logic       constant_vol;
    logic       halt;
  } env_t;

  function automatic logic [7:0] length_lookup(input logic [4:0] idx);
    logic [7:0] r;
    case (idx)
      5'd0: r = 8'd10;   5'd1: r = 8'd254; 5'd2: r = 8'd20;  5'd3: r = 8'd2;
      5'd4: r = 8'd40;   5'd5: r = 8'd4;   5'd6: r = 8'd80;  5'd7: r = 8'd6;
      5'd8: r = 8'd160;  5'd9: r = 8'd8;   5'd10: r = 8'd60; 5'd11: r = 8'd10;
      5'd12: r = 8'd14;  5'd13: r = 8'd12; 5'd14: r = 8'd26; 5'd15: r = 8'd14;
      5'd16: r = 8'd12;  5'd17: r = 8'd16; 5'd18: r = 8'd24; 5'd19: r = 8'd18;
      5'd20: r = 8'd48;  5'd21: r = 8'd20; 5'd22: r = 8'd96; 5'd23: r = 8'd22;
      5'd24: r = 8'd192; 5'd25: r = 8'd24; 5'd26: r = 8'd72; 5'd27: r = 8'd26;
      5'd28: r = 8'd16;  5'd29: r = 8'd28; 5'd30: r = 8'd32; default: r = 8'd30;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] noise_period_lookup(input logic [3:0] idx);
    logic [11:0] r;
    case (idx)
      4'd0: r = 12'd4;     4'd1: r = 12'd8;     4'd2: r = 12'd16;    4'd3: r = 12'd32;
      4'd4: r = 12'd64;    4'd5: r = 12'd96;    4'd6: r = 12'd128;   4'd7: r = 12'd160;
      4'd8: r = 12'd202;   4'd9: r = 12'd254;   4'd10: r = 12'd380;  4'd11: r = 12'd508;
      4'd12: r = 12'd762;  4'd13: r = 12'd1016; 4'd14: r = 12'd2034; default: r = 12'd4068;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] duty_lookup(input logic [1:0] mode);
    logic [7:0] r;
    case (mode)
      2'd0: r = 8'h02;
      2'd1: r = 8'h06;
      2'd2: r = 8'h1E;
      default: r = 8'hF9;
    endcase
    return r;
  endfunction

  function automatic env_t env_clock(input env_t e);
    env_t r;
    r = e;
    if (e.start) begin
      r.start = 1'b0;
      r.decay = 4'd15;
      r.divider = e.vol;
    end else if (e.divider != 4'd0) begin
      r.divider = e.divider - 4'd1;
    end else begin
      r.divider = e.vol;
      if (e.decay != 4'd0) r.decay = e.decay - 4'd1;
      else if (e.halt) r.decay = 4'd15;
    end
    return r;
  endfunction

  function automatic logic [7:0] length_half(input logic en, input logic halt,
                                             input logic [7:0] len);
    logic [7:0] r;
    r = len;
    if (!en) r = 8'd0;
    else if (!halt && len != 8'd0) r = len - 8'd1;
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/stnsu_pulse.sv =====
// One pulse channel: timer, duty sequencer, envelope, sweep and length counter.
`default_nettype none
module stnsu_pulse (
  input  wire              clk,
  input  wire              rst,
  input  wire              is_one,
  input  wire              tick_half,
  input  wire              quarter,
  input  wire              half,
  input  wire              wr,
  input  wire  [1:0]       wr_reg,
  input  wire              wr_status,
  input  wire  [7:0]       wdata,
  output logic             len_nz,
  output logic [3:0]       level
);
  import stnsu_pkg::*;

  logic [1:0]  duty_mode;
  logic [2:0]  duty_pos;
  logic [10:0] period;
  logic [10:0] countdown;
  logic [7:0]  length;
  logic        en, sweep_en, negate, sreload;
  env_t        env;
  logic [2:0]  sw_period, sw_shift, sw_div;

  logic [1:0]  duty_mode_next;
  logic [2:0]  duty_pos_next;
  logic [10:0] period_next;
  logic [10:0] countdown_next;
  logic [7:0]  length_next;
  logic        en_next, sweep_en_next, negate_next, sreload_next;
  env_t        env_next;
  logic [2:0]  sw_period_next, sw_shift_next, sw_div_next;

  logic [11:0] target;
  logic        muted;
  logic [7:0]  duty;

  function automatic logic [11:0] calc_target(input logic [10:0] p, input logic [2:0] sh,
                                              input logic neg, input logic one);
    logic [11:0] c, t;
    c = {1'b0, p >> sh};
    if (neg) t = {1'b0, p} - c - {11'd0, one};
    else t = {1'b0, p} + c;
    return t;
  endfunction

  always_comb begin
    target = calc_target(period, sw_shift, negate, is_one);
    muted = (period < 11'd8) || (sw_shift != 3'd0 && target > {1'b0, PERIOD_MAX});

    duty_mode_next = duty_mode;
    duty_pos_next = duty_pos;
    period_next = period;
    countdown_next = countdown;
    length_next = length;
    en_next = en;
    sweep_en_next = sweep_en;
    negate_next = negate;
    sreload_next = sreload;
    env_next = env;
    sw_period_next = sw_period;
    sw_shift_next = sw_shift;
    sw_div_next = sw_div;

    if (wr) begin
      case (wr_reg)
        PREG_CTRL: begin
          duty_mode_next = wdata[7:6];
          env_next.halt = wdata[5];
          env_next.constant_vol = wdata[4];
          env_next.vol = wdata[3:0];
        end
        PREG_SWEEP: begin
          sreload_next = 1'b1;
          sweep_en_next = wdata[7];
          negate_next = wdata[3];
          sw_period_next = wdata[6:4];
          sw_shift_next = wdata[2:0];
        end
        PREG_LO: period_next = {period[10:8], wdata};
        default: begin
          period_next = {wdata[2:0], period[7:0]};
          if (en) length_next = length_lookup(wdata[7:3]);
          countdown_next = {wdata[2:0], period[7:0]};
          duty_pos_next = 3'd0;
          env_next.start = 1'b1;
        end
      endcase
    end
    if (wr_status) begin
      en_next = wdata[0];
      if (!wdata[0]) length_next = 8'd0;
    end

    if (quarter) env_next = env_clock(env);
    if (half) begin
      length_next = length_half(en, env.halt, length);
      if (sw_div == 3'd0 && sweep_en && sw_shift != 3'd0 && !muted)
        period_next = target[10:0];
      if (sw_div == 3'd0 || sreload) begin
        sw_div_next = sw_period;
        sreload_next = 1'b0;
      end else begin
        sw_div_next = sw_div - 3'd1;
      end
    end

    if (tick_half) begin
      if (countdown == 11'd0) begin
        countdown_next = period_next;
        duty_pos_next = duty_pos + 3'd1;
      end else begin
        countdown_next = countdown - 11'd1;
      end
    end
  end

  always_comb begin
    duty = duty_lookup(duty_mode);
    len_nz = (length != 8'd0);
    if (!en || length == 8'd0 || muted || period < 11'd8 || !duty[duty_pos])
      level = 4'd0;
    else
      level = env.constant_vol ? env.vol : env.decay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_mode <= '0; duty_pos <= '0; period <= '0; countdown <= '0; length <= '0;
      en <= 1'b0; sweep_en <= 1'b0; negate <= 1'b0; sreload <= 1'b0;
      env <= '0; sw_period <= '0; sw_shift <= '0; sw_div <= '0;
    end else begin
      duty_mode <= duty_mode_next; duty_pos <= duty_pos_next;
      period <= period_next; countdown <= countdown_next; length <= length_next;
      en <= en_next; sweep_en <= sweep_en_next; negate <= negate_next;
      sreload <= sreload_next; env <= env_next; sw_period <= sw_period_next;
      sw_shift <= sw_shift_next; sw_div <= sw_div_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/square_triangle_noise_sound_unit_core.sv =====
// Top level: pulse pair, triangle, noise, frame sequencer and output register.
// A request's result is in the output register in the cycle after it is accepted.
// One request per cycle unless out_ready stalls; the state updates on acceptance.
// The output register is a single stage that is refilled while it is being taken.
// Reset is synchronous and active high; the noise shift register resets to one.
`default_nettype none
module square_triangle_noise_sound_unit_core (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [1:0] opcode,
  input  wire  [4:0] reg_offset,
  input  wire  [7:0] write_byte,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [3:0] read_byte,
  output logic [3:0] pulse_one_level,
  output logic [3:0] pulse_two_level,
  output logic [3:0] triangle_level,
  output logic [3:0] noise_level
);
  import stnsu_pkg::*;

  logic acc, is_tick, is_wr, tick_half, quarter, half, frame_wr, mode5_w;
  logic [14:0] seq_count, seq_count_next, seq_inc;
  logic mode5, mode5_next, parity;
  logic p0_nz, p1_nz;
  logic [3:0] p0_lvl, p1_lvl;

  logic        t_en, t_ctrl, t_rflag;
  logic [6:0]  t_rval, t_lin;
  logic [7:0]  t_len;
  logic [4:0]  t_step;
  logic [10:0] t_per, t_cnt;
  logic        t_en_next, t_ctrl_next, t_rflag_next;
  logic [6:0]  t_rval_next, t_lin_next;
  logic [7:0]  t_len_next;
  logic [4:0]  t_step_next;
  logic [10:0] t_per_next, t_cnt_next;

  env_t        n_env, n_env_next;
  logic        n_en, n_mode, n_en_next, n_mode_next;
  logic [11:0] n_per, n_cnt, n_per_next, n_cnt_next;
  logic [14:0] n_shift, n_shift_next;
  logic [7:0]  n_len, n_len_next;
  logic        fb;
  logic [3:0]  rd;

  assign in_ready = !out_valid || out_ready;
  assign acc = in_valid && in_ready;
  assign is_tick = acc && opcode == OP_TICK;
  assign is_wr = acc && opcode == OP_WRITE;
  assign tick_half = is_tick && parity;
  assign frame_wr = is_wr && reg_offset == OFF_FRAME;
  assign mode5_w = write_byte[7];
  assign seq_inc = seq_count + 15'd1;

  always_comb begin
    seq_count_next = seq_count;
    mode5_next = mode5;
    quarter = 1'b0;
    half = 1'b0;
    if (tick_half) begin
      seq_count_next = seq_inc;
      if (seq_inc == SEQ_Q1 || seq_inc == SEQ_Q3) begin
        quarter = 1'b1;
      end else if (seq_inc == SEQ_Q2) begin
        quarter = 1'b1; half = 1'b1;
      end else if (seq_inc == (mode5 ? SEQ_Q5 : SEQ_Q4)) begin
        quarter = 1'b1; half = 1'b1; seq_count_next = '0;
      end
    end
    if (frame_wr) begin
      mode5_next = mode5_w;
      seq_count_next = '0;
      quarter = mode5_w;
      half = mode5_w;
    end
  end

  stnsu_pulse u_p0 (
    .clk, .rst, .is_one(1'b1), .tick_half, .quarter, .half,
    .wr(is_wr && reg_offset[4:2] == 3'd0), .wr_reg(reg_offset[1:0]),
    .wr_status(is_wr && reg_offset == OFF_STATUS), .wdata(write_byte),
    .len_nz(p0_nz), .level(p0_lvl)
  );
  stnsu_pulse u_p1 (
    .clk, .rst, .is_one(1'b0), .tick_half, .quarter, .half,
    .wr(is_wr && reg_offset[4:2] == 3'd1), .wr_reg(reg_offset[1:0]),
    .wr_status(is_wr && reg_offset == OFF_STATUS),
    .wdata((reg_offset == OFF_STATUS) ? {1'b0, write_byte[7:1]} : write_byte),
    .len_nz(p1_nz), .level(p1_lvl)
  );

  always_comb begin
    t_en_next = t_en; t_ctrl_next = t_ctrl; t_rflag_next = t_rflag;
    t_rval_next = t_rval; t_lin_next = t_lin; t_len_next = t_len;
    t_step_next = t_step; t_per_next = t_per; t_cnt_next = t_cnt;
    n_env_next = n_env; n_en_next = n_en; n_mode_next = n_mode;
    n_per_next = n_per; n_cnt_next = n_cnt; n_shift_next = n_shift; n_len_next = n_len;
    fb = n_shift[0] ^ (n_mode ? n_shift[6] : n_shift[1]);

    if (is_tick) begin
      if (t_cnt == 11'd0) begin
        t_cnt_next = t_per;
        if (t_en && t_len != 8'd0 && t_lin != 7'd0 && t_per >= 11'd2)
          t_step_next = t_step + 5'd1;
      end else begin
        t_cnt_next = t_cnt - 11'd1;
      end
    end
    if (tick_half) begin
      if (n_cnt == 12'd0) begin
        n_cnt_next = n_per;
        n_shift_next = {fb, n_shift[14:1]};
      end else begin
        n_cnt_next = n_cnt - 12'd1;
      end
    end

    if (is_wr) begin
      case (reg_offset)
        OFF_TRI_LIN: begin
          t_ctrl_next = write_byte[7];
          t_rval_next = write_byte[6:0];
        end
        OFF_TRI_LO: t_per_next = {t_per[10:8], write_byte};
        OFF_TRI_HI: begin
          t_per_next = {write_byte[2:0], t_per[7:0]};
          if (t_en) t_len_next = length_lookup(write_byte[7:3]);
          t_cnt_next = {write_byte[2:0], t_per[7:0]};
          t_rflag_next = 1'b1;
        end
        OFF_NOI_ENV: begin
          n_env_next.halt = write_byte[5];
          n_env_next.constant_vol = write_byte[4];
          n_env_next.vol = write_byte[3:0];
        end
        OFF_NOI_PER: begin
          n_mode_next = write_byte[7];
          n_per_next = noise_period_lookup(write_byte[3:0]);
          n_cnt_next = noise_period_lookup(write_byte[3:0]);
        end
        OFF_NOI_LEN: begin
          if (n_en) n_len_next = length_lookup(write_byte[7:3]);
          n_cnt_next = n_per;
          n_env_next.start = 1'b1;
        end
        OFF_STATUS: begin
          t_en_next = write_byte[2];
          n_en_next = write_byte[3];
          if (!write_byte[2]) t_len_next = 8'd0;
          if (!write_byte[3]) n_len_next = 8'd0;
        end
        default: ;
      endcase
    end

    if (quarter) begin
      n_env_next = env_clock(n_env);
      if (t_rflag) t_lin_next = t_rval;
      else if (t_lin != 7'd0) t_lin_next = t_lin - 7'd1;
      if (!t_ctrl) t_rflag_next = 1'b0;
    end
    if (half) begin
      t_len_next = length_half(t_en, t_ctrl, t_len);
      n_len_next = length_half(n_en, n_env.halt, n_len);
    end
  end

  assign rd = {n_len != 8'd0, t_len != 8'd0, p1_nz, p0_nz};

  logic rd_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rd_q <= 1'b0;
      seq_count <= '0; mode5 <= 1'b0; parity <= 1'b0;
      t_en <= 1'b0; t_ctrl <= 1'b0; t_rflag <= 1'b0; t_rval <= '0; t_lin <= '0;
      t_len <= '0; t_step <= '0; t_per <= '0; t_cnt <= '0;
      n_env <= '0; n_en <= 1'b0; n_mode <= 1'b0; n_per <= '0; n_cnt <= '0;
      n_shift <= 15'd1; n_len <= '0;
    end else begin
      if (acc) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (acc) rd_q <= (opcode == OP_READ && reg_offset == OFF_STATUS);
      if (is_tick) parity <= !parity;
      seq_count <= seq_count_next; mode5 <= mode5_next;
      t_en <= t_en_next; t_ctrl <= t_ctrl_next; t_rflag <= t_rflag_next;
      t_rval <= t_rval_next; t_lin <= t_lin_next; t_len <= t_len_next;
      t_step <= t_step_next; t_per <= t_per_next; t_cnt <= t_cnt_next;
      n_env <= n_env_next; n_en <= n_en_next; n_mode <= n_mode_next;
      n_per <= n_per_next; n_cnt <= n_cnt_next; n_shift <= n_shift_next;
      n_len <= n_len_next;
    end
  end

  always_comb begin
    read_byte = rd_q ? rd : 4'd0;
    pulse_one_level = p0_lvl;
    pulse_two_level = p1_lvl;
    if (!t_en || t_len == 8'd0 || t_lin == 7'd0 || t_per < 11'd2)
      triangle_level = 4'd0;
    else
      triangle_level = t_step[4] ? t_step[3:0] : ~t_step[3:0];
    if (!n_en || n_len == 8'd0 || n_shift[0])
      noise_level = 4'd0;
    else
      noise_level = n_env.constant_vol ? n_env.vol : n_env.decay;
  end
endmodule
`default_nettype wire
